@@ src/jsv_pkg.sv @@
// shared constants, codes and literal tables for the json syntax validator
package jsv_pkg;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_OBJECT = 3'd1;
    localparam logic [2:0] KIND_ARRAY  = 3'd2;
    localparam logic [2:0] KIND_STRING = 3'd3;
    localparam logic [2:0] KIND_TRUE   = 3'd4;
    localparam logic [2:0] KIND_FALSE  = 3'd5;
    localparam logic [2:0] KIND_NULL   = 3'd6;
    localparam logic [2:0] KIND_NUMBER = 3'd7;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [5:0] NEST_LIMIT_RESET = 6'd32;

    typedef struct packed {
        logic       text_valid;
        logic [2:0] value_kind;
        logic [15:0] value_offset;
        logic [16:0] value_length;
    } jsv_result_t;

    function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (which)
            LIT_TRUE:
                unique case (idx)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            LIT_FALSE:
                unique case (idx)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            LIT_NULL:
                unique case (idx)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] which);
        logic [2:0] n;
        unique case (which)
            LIT_FALSE: n = 3'd5;
            LIT_TRUE, LIT_NULL: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

endpackage

@@ src/json_syntax_validator_core.sv @@
// json syntax validator top level: byte scanner around the nesting stack memory
//
//  channel  | dir | handshake              | word
//  s_axis   | in  | s_tvalid / s_tready    | s_tdata text_byte, s_tlast last_byte
//  m_axis   | out | m_tvalid / m_tready    | m_tdata result of one text
//  apb      | in  | psel / penable / pready| nesting_limit at address 0
//
// one byte per cycle; the stack top is cached in a register and refilled from the
// registered stack memory read in the cycle after a close, so closes can follow each other.
// results sit in an output register; a last byte stalls only while it is full and m_tready is low.
// asynchronous active-low reset; the stack memory itself is never cleared.
module json_syntax_validator_core #(
    parameter int MAX_NEST       = 32,
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // text_valid, value_kind[3], value_offset[16], value_length[17]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jsv_pkg::*;

    localparam int LW = $clog2(MAX_NEST + 1);
    localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int PW = $clog2(MAX_TEXT_BYTES + 1);

    typedef enum logic [4:0] {
        M_LEAD, M_VALUE, M_FIRST_ARR, M_FIRST_OBJ, M_KEY, M_COLON, M_AFTER,
        M_TRAIL, M_STR, M_STR_ESC, M_STR_HEX, M_LIT, M_NUM_MINUS, M_NUM_ZERO,
        M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_NUM_E, M_NUM_ESIGN, M_NUM_EXP
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [LW-1:0] level_reg, level_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]  lp_reg, lp_next;
    logic [1:0]  wl_reg, wl_next;
    logic [2:0]  hex_reg, hex_next;
    logic [PW-1:0] ts_reg, ts_next;
    logic [PW-1:0] te_reg, te_next;
    logic [2:0]  tk_reg, tk_next;
    logic        err_reg, err_next;
    logic        key_reg, key_next;
    logic        top_reg, top_next;
    logic        from_mem_reg, from_mem_next;
    logic [5:0]  limit_reg;
    logic        out_valid_reg;
    jsv_result_t out_reg, out_next;

    logic        accept;
    logic        push;
    logic        push_kind;
    logic [LW-1:0] push_level;
    logic        rd_data;
    logic        top_obj;
    logic [LW-1:0] eff_limit;
    logic [LW-1:0] rd_level;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !(s_tlast && out_valid_reg && !m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.value_length, out_reg.value_offset,
                       out_reg.value_kind, out_reg.text_valid};
    assign pready   = 1'b1;
    assign prdata   = (paddr == 3'd0) ? {26'd0, limit_reg} : 32'd0;

    assign eff_limit = (int'(limit_reg) > MAX_NEST) ? LW'(MAX_NEST) : LW'(limit_reg);
    assign top_obj   = from_mem_reg ? rd_data : top_reg;
    assign rd_level  = level_reg - LW'(2);

    jsv_stack_ram #(.DEPTH(MAX_NEST), .AW(AW)) u_stack (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (AW'(push_level)),
        .wr_data (push_kind),
        .rd_addr (AW'(rd_level)),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic [7:0]  c;
        logic        bv, vd, redo, aft, trl, cls;
        logic [PW-1:0] vd_end;
        logic [LW-1:0] lvl0;
        logic [2:0]  kind;
        logic        fin;
        c = s_tdata;
        bv = 1'b0; vd = 1'b0; redo = 1'b0; aft = 1'b0; trl = 1'b0; cls = 1'b0;
        vd_end = pos_reg;
        kind = KIND_NONE;
        lvl0 = level_reg;
        fin = 1'b0;
        mode_next = mode_reg;
        level_next = level_reg;
        pos_next = pos_reg;
        lp_next = lp_reg;
        wl_next = wl_reg;
        hex_next = hex_reg;
        ts_next = ts_reg;
        te_next = te_reg;
        tk_next = tk_reg;
        err_next = err_reg;
        key_next = key_reg;
        top_next = top_obj;
        from_mem_next = 1'b0;
        push = 1'b0;
        push_kind = 1'b0;
        push_level = level_reg;
        out_next = out_reg;

        if (accept)
        begin
            if (pos_reg >= PW'(MAX_TEXT_BYTES))
            begin
                err_next = 1'b1;
            end
            else
            begin
                if (!err_reg)
                begin
                    unique case (mode_reg)
                        M_LEAD, M_VALUE:
                            if (!is_space(c)) bv = 1'b1;
                        M_FIRST_ARR:
                            if (!is_space(c))
                            begin
                                if (c == "]") cls = 1'b1;
                                else bv = 1'b1;
                            end
                        M_FIRST_OBJ, M_KEY:
                            if (!is_space(c))
                            begin
                                if (mode_reg == M_FIRST_OBJ && c == "}") cls = 1'b1;
                                else if (c == "\"")
                                begin
                                    key_next = 1'b1;
                                    mode_next = M_STR;
                                end
                                else err_next = 1'b1;
                            end
                        M_COLON:
                            if (!is_space(c))
                            begin
                                if (c == ":") mode_next = M_VALUE;
                                else err_next = 1'b1;
                            end
                        M_AFTER: aft = 1'b1;
                        M_TRAIL: trl = 1'b1;
                        M_STR:
                            if (c == "\"")
                            begin
                                if (key_reg)
                                begin
                                    key_next = 1'b0;
                                    mode_next = M_COLON;
                                end
                                else
                                begin
                                    vd = 1'b1;
                                    vd_end = pos_reg + PW'(1);
                                end
                            end
                            else if (c < CTRL_LIMIT) err_next = 1'b1;
                            else if (c == "\\") mode_next = M_STR_ESC;
                        M_STR_ESC:
                            if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                                c == "n" || c == "r" || c == "t")
                                mode_next = M_STR;
                            else if (c == "u")
                            begin
                                hex_next = 3'd4;
                                mode_next = M_STR_HEX;
                            end
                            else err_next = 1'b1;
                        M_STR_HEX:
                            if (!is_hex(c)) err_next = 1'b1;
                            else
                            begin
                                hex_next = (hex_reg != 3'd0) ? hex_reg - 3'd1 : hex_reg;
                                if (hex_next == 3'd0) mode_next = M_STR;
                            end
                        M_LIT:
                            if (wl_reg > LIT_NULL || lp_reg >= lit_len(wl_reg) ||
                                c != lit_char(wl_reg, lp_reg))
                                err_next = 1'b1;
                            else
                            begin
                                lp_next = lp_reg + 3'd1;
                                if (lp_next == lit_len(wl_reg))
                                begin
                                    vd = 1'b1;
                                    vd_end = pos_reg + PW'(1);
                                end
                            end
                        M_NUM_MINUS:
                            if (c == "0") mode_next = M_NUM_ZERO;
                            else if (is_digit(c)) mode_next = M_NUM_INT;
                            else err_next = 1'b1;
                        M_NUM_DOT:
                            if (is_digit(c)) mode_next = M_NUM_FRAC;
                            else err_next = 1'b1;
                        M_NUM_E:
                            if (c == "+" || c == "-") mode_next = M_NUM_ESIGN;
                            else if (is_digit(c)) mode_next = M_NUM_EXP;
                            else err_next = 1'b1;
                        M_NUM_ESIGN:
                            if (is_digit(c)) mode_next = M_NUM_EXP;
                            else err_next = 1'b1;
                        M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC, M_NUM_EXP:
                            if (is_digit(c) && mode_reg != M_NUM_ZERO) ;
                            else if (c == "." && (mode_reg == M_NUM_ZERO ||
                                                  mode_reg == M_NUM_INT))
                                mode_next = M_NUM_DOT;
                            else if ((c == "e" || c == "E") && mode_reg != M_NUM_EXP)
                                mode_next = M_NUM_E;
                            else
                            begin
                                vd = 1'b1;
                                vd_end = pos_reg;
                                redo = 1'b1;
                            end
                        default: err_next = 1'b1;
                    endcase

                    if (vd)
                    begin
                        if (level_next == LW'(0))
                        begin
                            te_next = vd_end;
                            mode_next = M_TRAIL;
                        end
                        else mode_next = M_AFTER;
                    end

                    // a number ends on the byte after it: that byte is scanned again
                    if (redo)
                    begin
                        if (mode_next == M_AFTER) aft = 1'b1;
                        else trl = 1'b1;
                    end

                    if (trl && !is_space(c)) err_next = 1'b1;

                    if (aft && !is_space(c))
                    begin
                        if (level_next == LW'(0)) err_next = 1'b1;
                        else if (c == ",") mode_next = top_obj ? M_KEY : M_VALUE;
                        else if ((c == "}" && top_obj) || (c == "]" && !top_obj)) cls = 1'b1;
                        else err_next = 1'b1;
                    end

                    if (cls)
                    begin
                        level_next = level_next - LW'(1);
                        from_mem_next = 1'b1;
                        if (level_next == LW'(0))
                        begin
                            te_next = pos_reg + PW'(1);
                            mode_next = M_TRAIL;
                        end
                        else mode_next = M_AFTER;
                    end

                    if (bv)
                    begin
                        priority if (c == "{" || c == "[")
                        begin
                            kind = (c == "{") ? KIND_OBJECT : KIND_ARRAY;
                            if (level_reg >= eff_limit) err_next = 1'b1;
                            else
                            begin
                                push = 1'b1;
                                push_kind = (c == "{");
                                level_next = level_reg + LW'(1);
                                top_next = push_kind;
                                mode_next = push_kind ? M_FIRST_OBJ : M_FIRST_ARR;
                            end
                        end
                        else if (c == "\"")
                        begin
                            kind = KIND_STRING;
                            key_next = 1'b0;
                            mode_next = M_STR;
                        end
                        else if (c == "t" || c == "f" || c == "n")
                        begin
                            kind = (c == "t") ? KIND_TRUE : (c == "f") ? KIND_FALSE : KIND_NULL;
                            wl_next = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
                            lp_next = 3'd1;
                            mode_next = M_LIT;
                        end
                        else if (c == "-")
                        begin
                            kind = KIND_NUMBER;
                            mode_next = M_NUM_MINUS;
                        end
                        else if (c == "0")
                        begin
                            kind = KIND_NUMBER;
                            mode_next = M_NUM_ZERO;
                        end
                        else if (is_digit(c))
                        begin
                            kind = KIND_NUMBER;
                            mode_next = M_NUM_INT;
                        end
                        else err_next = 1'b1;
                        if (lvl0 == LW'(0) && !err_next)
                        begin
                            ts_next = pos_reg;
                            tk_next = kind;
                        end
                    end
                end
                pos_next = pos_reg + PW'(1);
            end

            if (s_tlast)
            begin
                if (!err_next && (mode_next == M_NUM_ZERO || mode_next == M_NUM_INT ||
                                  mode_next == M_NUM_FRAC || mode_next == M_NUM_EXP))
                begin
                    if (level_next == LW'(0))
                    begin
                        te_next = pos_next;
                        mode_next = M_TRAIL;
                    end
                    else mode_next = M_AFTER;
                end
                fin = !err_next && mode_next == M_TRAIL && level_next == LW'(0);
                out_next.text_valid   = fin;
                out_next.value_kind   = fin ? tk_next : KIND_NONE;
                out_next.value_offset = fin ? 16'(ts_next) : 16'd0;
                out_next.value_length = fin ? 17'(te_next - ts_next) : 17'd0;
                mode_next = M_LEAD;
                level_next = '0;
                pos_next = '0;
                lp_next = 3'd0;
                wl_next = 2'd0;
                hex_next = 3'd0;
                ts_next = '0;
                te_next = '0;
                tk_next = KIND_NONE;
                err_next = 1'b0;
                key_next = 1'b0;
                from_mem_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_LEAD;
            level_reg     <= '0;
            pos_reg       <= '0;
            lp_reg        <= 3'd0;
            wl_reg        <= 2'd0;
            hex_reg       <= 3'd0;
            ts_reg        <= '0;
            te_reg        <= '0;
            tk_reg        <= KIND_NONE;
            err_reg       <= 1'b0;
            key_reg       <= 1'b0;
            top_reg       <= 1'b0;
            from_mem_reg  <= 1'b0;
            limit_reg     <= NEST_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            level_reg    <= level_next;
            pos_reg      <= pos_next;
            lp_reg       <= lp_next;
            wl_reg       <= wl_next;
            hex_reg      <= hex_next;
            ts_reg       <= ts_next;
            te_reg       <= te_next;
            tk_reg       <= tk_next;
            err_reg      <= err_next;
            key_reg      <= key_next;
            top_reg      <= top_next;
            from_mem_reg <= from_mem_next;
            if (psel && penable && pwrite && paddr == 3'd0)
            begin
                limit_reg <= pwdata[5:0];
            end
            if (accept && s_tlast) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            out_reg <= out_next;
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(level_reg) <= MAX_NEST)
        else $error("nesting level beyond stack depth");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[39:1] == 39'd0))
        else $error("invalid result carries nonzero fields");

    a_refill_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        from_mem_reg |-> ($past(level_reg) == level_reg + LW'(1)))
        else $error("stack refill without a close");
endmodule

@@ src/jsv_stack_ram.sv @@
// nesting kind stack: one write port, one registered read port
module jsv_stack_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);
    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule
